// File: rtl/bts_pkg.sv
// shared types, constants and helpers for the banked top-n score table
// no dependencies; used by bts_cell and banked_top_n_sorted_insert_top
package bts_pkg;

    localparam int BANKS   = 10;
    localparam int ENTRIES = 10;
    localparam int BANK_W  = $clog2(BANKS);

    localparam logic [31:0] RESET_TIME = 32'd946713600;

    localparam logic [1:0] REQ_CHECK  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef enum logic [1:0] {
        K_NONE,
        K_CHECK,
        K_INSERT,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [31:0] score;
        logic [31:0] player;
        logic [31:0] stamp;
    } t_entry;

    // request token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        valid_res;
        logic [3:0]  bank;
        logic [3:0]  slot;
        logic        placed;
        logic [3:0]  rank;
        t_entry      carry;
    } t_tok;

    function automatic logic [31:0] default_score(input int j);
        logic [31:0] s;
        case (j)
            0:       s = 32'd250000;
            1:       s = 32'd200000;
            2:       s = 32'd150000;
            3:       s = 32'd100000;
            4:       s = 32'd50000;
            default: s = 32'd99;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/bts_cell.sv
// one list position of the score table, holding that position for every bank
// depends on bts_pkg for the token and entry types
module bts_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(bts_pkg::ENTRIES)-1:0] i_idx,
    input  bts_pkg::t_tok                       i_tok,
    output bts_pkg::t_tok                       o_tok
);

    bts_pkg::t_entry r_store [bts_pkg::BANKS];
    bts_pkg::t_tok   r_tok;
    bts_pkg::t_tok   n_tok;
    bts_pkg::t_entry w_ent;
    logic            w_beat;
    logic            w_wr;

    always_comb begin
        w_ent  = r_store[i_tok.bank[bts_pkg::BANK_W-1:0]];
        n_tok  = i_tok;
        w_wr   = 1'b0;
        w_beat = !i_tok.placed && (i_tok.carry.score > w_ent.score);
        case (i_tok.kind)
            bts_pkg::K_CHECK: begin
                if (w_beat) begin
                    n_tok.placed = 1'b1;
                    n_tok.rank   = 4'(i_idx) + 4'd1;
                end
            end
            bts_pkg::K_INSERT: begin
                if (w_beat) begin
                    n_tok.placed = 1'b1;
                    n_tok.rank   = 4'(i_idx) + 4'd1;
                end
                // from the first beaten slot on, swap: store carried, pass old down
                if (w_beat || i_tok.placed) begin
                    w_wr        = i_tok.valid;
                    n_tok.carry = w_ent;
                end
            end
            bts_pkg::K_READ: begin
                if (i_tok.slot == 4'(i_idx)) begin
                    n_tok.carry = w_ent;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            for (int b = 0; b < bts_pkg::BANKS; b++) begin
                r_store[b].score  <= bts_pkg::default_score(int'(i_idx));
                r_store[b].player <= 32'd0;
                r_store[b].stamp  <= bts_pkg::RESET_TIME;
            end
        end else begin
            r_tok <= n_tok;
            if (w_wr) begin
                r_store[i_tok.bank[bts_pkg::BANK_W-1:0]] <= i_tok.carry;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/banked_top_n_sorted_insert_top.sv
// top level of the banked top-n score table: request decode, cell row, output register
// depends on bts_pkg and bts_cell
//
// Keeps a descending top-N list in each bank (banks 1 to BANKS-1 usable) as a
// row of ENTRIES cells, one per list position, each holding that position for
// every bank. An accepted word is decoded into a token that walks the row one
// cell per cycle: a check or insert compares the carried score in each cell,
// an insert swaps the carried entry in from the first beaten slot on so that
// lower entries shift down and the last drops off, and a read picks up the
// entry at its slot. One request is handled at a time. The accepting edge
// loads the launch register, the token then passes the registers of the
// ENTRIES cells in order, and the output register takes the result word.
// The next word is taken as soon as the result sits in the output register,
// even while the output is stalled; a result that meets a full, stalled
// output waits in the holding stage and keeps the input stalled until it
// moves into the output register.
// The player tag register is always ready and is captured at request launch.
module banked_top_n_sorted_insert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_skill,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_new_score,
    input  logic [31:0] i_stamp,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_rank,
    output logic        o_valid_res,
    output logic [31:0] o_entry_score,
    output logic [31:0] o_entry_player,
    output logic [31:0] o_entry_time,
    // player tag register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int E = bts_pkg::ENTRIES;

    typedef struct packed {
        logic [3:0]      rank;
        logic            valid_res;
        bts_pkg::t_entry ent;
    } t_res;

    logic [31:0]   r_player_tag;
    bts_pkg::t_tok r_launch;
    bts_pkg::t_tok n_launch;
    bts_pkg::t_tok w_tok [E+1];
    logic [E-1:0]  w_live;

    logic          r_busy;
    logic          r_hold_valid;
    t_res          r_hold;
    logic          r_out_valid;
    t_res          r_out;
    t_res          w_exit_res;

    logic          w_accept;
    logic          w_out_free;
    logic          w_exit;
    logic          w_bank_ok;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign w_accept    = i_in_valid && !r_busy;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // player tag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_tag <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_player_tag <= i_cfg_data;
        end
    end

    // request decode into a launch token
    assign w_bank_ok = (i_skill != 4'd0) && (32'(i_skill) < bts_pkg::BANKS);

    always_comb begin
        n_launch              = '0;
        n_launch.valid        = w_accept;
        n_launch.kind         = bts_pkg::K_NONE;
        n_launch.carry.score  = i_new_score;
        n_launch.carry.player = r_player_tag;
        n_launch.carry.stamp  = i_stamp;
        n_launch.slot         = i_slot;
        unique case (i_req_type)
            bts_pkg::REQ_CHECK: begin
                if (w_bank_ok) begin
                    n_launch.kind      = bts_pkg::K_CHECK;
                    n_launch.valid_res = 1'b1;
                end
            end
            bts_pkg::REQ_INSERT: begin
                if (w_bank_ok) begin
                    n_launch.kind      = bts_pkg::K_INSERT;
                    n_launch.valid_res = 1'b1;
                end
            end
            bts_pkg::REQ_READ: begin
                if (w_bank_ok && (32'(i_slot) < E)) begin
                    n_launch.kind      = bts_pkg::K_READ;
                    n_launch.valid_res = 1'b1;
                end
            end
            default: ;
        endcase
        // idle tokens point at bank 0 so no cell reads past its store
        if (n_launch.kind != bts_pkg::K_NONE) begin
            n_launch.bank = i_skill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
        end else begin
            r_launch <= n_launch;
        end
    end

    // row of list-position cells, token handed on every cycle
    assign w_tok[0] = r_launch;

    for (genvar g = 0; g < E; g++) begin : g_cell
        bts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   ($clog2(E)'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_live[g] = w_tok[g+1].valid;
    end

    // result word from the token leaving the last cell
    assign w_exit = w_tok[E].valid;

    always_comb begin
        w_exit_res.rank      = w_tok[E].rank;
        w_exit_res.valid_res = w_tok[E].valid_res;
        w_exit_res.ent       = '0;
        if (w_tok[E].kind == bts_pkg::K_READ) begin
            w_exit_res.ent = w_tok[E].carry;
        end
    end

    // output register plus one holding stage for a result that meets a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end
            if (r_hold_valid && w_out_free) begin
                r_out        <= r_hold;
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
                r_busy       <= 1'b0;
            end else if (w_exit && w_out_free) begin
                r_out       <= w_exit_res;
                r_out_valid <= 1'b1;
                r_busy      <= 1'b0;
            end else if (w_exit) begin
                r_hold       <= w_exit_res;
                r_hold_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rank         = r_out.rank;
    assign o_valid_res    = r_out.valid_res;
    assign o_entry_score  = r_out.ent.score;
    assign o_entry_player = r_out.ent.player;
    assign o_entry_time   = r_out.ent.stamp;

`ifndef SYNTHESIS
    // at most one request is ever in the cell row
    a_one_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live))
        else $error("more than one token in the cell row");

    // a token only leaves the row while a request is outstanding
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit |-> r_busy)
        else $error("token left the row with no request outstanding");

    // the holding stage is used only behind a full, stalled output
    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_out_valid)
        else $error("holding stage filled while output register empty");

    // a nonzero rank only comes with a valid bank
    a_rank_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_rank != 4'd0)) |-> o_valid_res)
        else $error("rank reported for an invalid request");
`endif

endmodule
